// ----- rtl/command_frame_unpacker_macros.svh -----
// Assertion macros for the command frame unpacker.
// Used by rtl/command_frame_unpacker.sv; expects clk and rst_n in scope.
`ifndef COMMAND_FRAME_UNPACKER_MACROS_SVH
`define COMMAND_FRAME_UNPACKER_MACROS_SVH

// same-cycle implication
`define CFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfu_pkg.sv -----
// Shared types and codes for the command frame unpacker.
// No dependencies; used by rtl/cfu_assembler.sv and rtl/command_frame_unpacker.sv.
package cfu_pkg;

  typedef enum logic [1:0] {
    FT_LIGHT = 2'd0,
    FT_ALARM = 2'd1,
    FT_CLOCK = 2'd2,
    FT_NONE  = 2'd3
  } frame_type_t;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_BAD    = 2'd3
  } alarm_act_t;

  typedef enum logic [2:0] {
    KIND_LIGHT        = 3'd0,
    KIND_ALARM_CREATE = 3'd1,
    KIND_ALARM_DELETE = 3'd2,
    KIND_ALARM_CLEAR  = 3'd3,
    KIND_CLOCK        = 3'd4
  } cmd_kind_t;

  // config register indexes
  localparam logic [1:0] REG_ALL_GROUPS    = 2'd0;
  localparam logic [1:0] REG_TOP_GROUP     = 2'd1;
  localparam logic [1:0] REG_DRAWER_GROUP  = 2'd2;

  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_LAST  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  light_group;
    logic [3:0]  effect;
    logic [31:0] color_rgba;
    logic [6:0]  day_of_week;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [6:0]  year;
    logic [9:0]  sound_snooze;
  } rec_t;

  // assembler status toward the output stage
  typedef struct packed {
    logic       at_last;   // current byte completes a frame
    logic       emit;      // current byte yields a record
    logic       dual;      // and a second one for the drawer group
    logic [1:0] group2;
  } asm_st_t;

endpackage

// ----- rtl/cfu_if.sv -----
// Handshake channels of the command frame unpacker: byte input and record output.
// Depends on nothing; payload fields follow cfu_pkg::rec_t.
interface cfu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfu_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  light_group;
  logic [3:0]  effect;
  logic [31:0] color_rgba;
  logic [6:0]  day_of_week;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [4:0]  day_of_month;
  logic [3:0]  month;
  logic [6:0]  year;
  logic [9:0]  sound_snooze;

  modport source (output valid, output kind, output light_group, output effect,
                  output color_rgba, output day_of_week, output hour, output minute,
                  output second, output day_of_month, output month, output year,
                  output sound_snooze, input ready);
  modport sink   (input valid, input kind, input light_group, input effect,
                  input color_rgba, input day_of_week, input hour, input minute,
                  input second, input day_of_month, input month, input year,
                  input sound_snooze, output ready);
endinterface

// ----- rtl/cfu_assembler.sv -----
// Frame assembler: byte position, frame type and held fields; builds records.
// Depends on cfu_pkg.
module cfu_assembler (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_fire,
  input  logic [7:0]       rx_byte,
  input  logic [1:0]       all_groups_code,
  input  logic [1:0]       top_group_code,
  input  logic [1:0]       drawer_group_code,
  output cfu_pkg::rec_t    rec,
  output cfu_pkg::asm_st_t st
);

  logic [2:0]           pos_r, pos_nxt;
  cfu_pkg::frame_type_t type_r, type_nxt, cur_type;
  logic [1:0]  group_r,   group_nxt;
  logic [3:0]  effect_r,  effect_nxt;
  logic [23:0] color_r,   color_nxt;
  logic [4:0]  sound_r,   sound_nxt;
  logic [6:0]  wday_r,    wday_nxt;
  logic [1:0]  action_r,  action_nxt;
  logic [4:0]  snooze_r,  snooze_nxt;
  logic [4:0]  hour_r,    hour_nxt;
  logic [5:0]  minute_r,  minute_nxt;
  logic [5:0]  second_r,  second_nxt;
  logic [4:0]  day_r,     day_nxt;
  logic [3:0]  month_r,   month_nxt;
  logic        last;

  assign cur_type = (pos_r == cfu_pkg::POS_FIRST) ? cfu_pkg::frame_type_t'(rx_byte[7:6])
                                                  : type_r;
  assign last = (pos_r == cfu_pkg::POS_LAST);

  always_comb begin
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    group_nxt  = group_r;
    effect_nxt = effect_r;
    color_nxt  = color_r;
    sound_nxt  = sound_r;
    wday_nxt   = wday_r;
    action_nxt = action_r;
    snooze_nxt = snooze_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    if (cur_type != cfu_pkg::FT_NONE) begin
      type_nxt = cur_type;
      pos_nxt  = last ? cfu_pkg::POS_FIRST : pos_r + 3'd1;
      if (last) begin
        type_nxt = cfu_pkg::FT_LIGHT;
      end
    end
    case (cur_type)
      cfu_pkg::FT_LIGHT: begin
        case (pos_r)
          3'd0: begin
            group_nxt  = rx_byte[5:4];
            effect_nxt = rx_byte[3:0];
          end
          3'd1:    color_nxt[23:16] = rx_byte;
          3'd2:    color_nxt[15:8]  = rx_byte;
          3'd3:    color_nxt[7:0]   = rx_byte;
          default: ;
        endcase
      end
      cfu_pkg::FT_ALARM: begin
        case (pos_r)
          3'd0: begin
            sound_nxt = rx_byte[5:1];
            wday_nxt  = {rx_byte[0], 6'd0};
          end
          3'd1: begin
            wday_nxt   = {wday_r[6], rx_byte[7:2]};
            action_nxt = rx_byte[1:0];
          end
          3'd2: begin
            snooze_nxt = rx_byte[7:3];
            hour_nxt   = {rx_byte[2:0], 2'd0};
          end
          3'd3: begin
            hour_nxt   = {hour_r[4:2], rx_byte[7:6]};
            minute_nxt = rx_byte[5:0];
          end
          default: ;
        endcase
      end
      cfu_pkg::FT_CLOCK: begin
        case (pos_r)
          3'd0: second_nxt = rx_byte[5:0];
          3'd1: minute_nxt = rx_byte[5:0];
          3'd2: begin
            hour_nxt = rx_byte[7:3];
            wday_nxt = {4'd0, rx_byte[2:0]};
          end
          3'd3: begin
            day_nxt   = rx_byte[7:3];
            month_nxt = {rx_byte[2:0], 1'b0};
          end
          default: month_nxt = {month_r[3:1], rx_byte[7]};
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= cfu_pkg::POS_FIRST;
      type_r   <= cfu_pkg::FT_LIGHT;
      group_r  <= '0;
      effect_r <= '0;
      color_r  <= '0;
      sound_r  <= '0;
      wday_r   <= '0;
      action_r <= '0;
      snooze_r <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      day_r    <= '0;
      month_r  <= '0;
    end else if (byte_fire) begin
      pos_r    <= pos_nxt;
      type_r   <= type_nxt;
      group_r  <= group_nxt;
      effect_r <= effect_nxt;
      color_r  <= color_nxt;
      sound_r  <= sound_nxt;
      wday_r   <= wday_nxt;
      action_r <= action_nxt;
      snooze_r <= snooze_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
    end
  end

  // record for the completing byte; unused fields stay zero
  always_comb begin
    rec       = '0;
    st.at_last = last;
    st.emit    = 1'b0;
    st.dual    = 1'b0;
    st.group2  = drawer_group_code;
    case (type_r)
      cfu_pkg::FT_LIGHT: begin
        st.emit         = last;
        st.dual         = last && (group_r == all_groups_code);
        rec.kind        = cfu_pkg::KIND_LIGHT;
        rec.light_group = (group_r == all_groups_code) ? top_group_code : group_r;
        rec.effect      = effect_r;
        rec.color_rgba  = {color_r, rx_byte};
      end
      cfu_pkg::FT_ALARM: begin
        case (cfu_pkg::alarm_act_t'(action_r))
          cfu_pkg::ACT_CREATE, cfu_pkg::ACT_DELETE: begin
            st.emit          = last;
            rec.kind         = (action_r == cfu_pkg::ACT_CREATE) ? cfu_pkg::KIND_ALARM_CREATE
                                                                 : cfu_pkg::KIND_ALARM_DELETE;
            rec.day_of_week  = wday_r;
            rec.hour         = hour_r;
            rec.minute       = minute_r;
            rec.sound_snooze = {sound_r, snooze_r};
          end
          cfu_pkg::ACT_CLEAR: begin
            st.emit  = last;
            rec.kind = cfu_pkg::KIND_ALARM_CLEAR;
          end
          default: ;
        endcase
      end
      cfu_pkg::FT_CLOCK: begin
        st.emit          = last;
        rec.kind         = cfu_pkg::KIND_CLOCK;
        rec.day_of_week  = wday_r;
        rec.hour         = hour_r;
        rec.minute       = minute_r;
        rec.second       = second_r;
        rec.day_of_month = day_r;
        rec.month        = {month_r[3:1], rx_byte[7]};
        rec.year         = rx_byte[6:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/command_frame_unpacker.sv -----
// A record, when the frame yields one, appears in the cycle after the transfer of a frame's fifth byte.
// Throughput: one byte per cycle but for the fifth-byte wait below; an all-groups light frame
// puts out two records, one after the other, from one output register.
// The fifth byte waits only while the previous frame's record is still held.
// Reset (rst_n, synchronous, active low) returns to the first byte of a frame,
// clears held fields and sets group codes to all=3, top=0, drawer=1.
`include "command_frame_unpacker_macros.svh"

module command_frame_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  cfu_byte_if.sink    in_if,
  cfu_rec_if.source   out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0]       all_code_r, top_code_r, drawer_code_r;
  cfu_pkg::rec_t    rec, out_rec_r;
  cfu_pkg::asm_st_t st;
  logic             out_valid_r, dual_r;
  logic [1:0]       group2_r;
  logic             in_fire, out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_code_r    <= 2'd3;
      top_code_r    <= 2'd0;
      drawer_code_r <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cfu_pkg::REG_ALL_GROUPS:   all_code_r    <= cfg_wdata;
        cfu_pkg::REG_TOP_GROUP:    top_code_r    <= cfg_wdata;
        cfu_pkg::REG_DRAWER_GROUP: drawer_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfu_assembler u_asm (
    .clk               (clk),
    .rst_n             (rst_n),
    .byte_fire         (in_fire),
    .rx_byte           (in_if.rx_byte),
    .all_groups_code   (all_code_r),
    .top_group_code    (top_code_r),
    .drawer_group_code (drawer_code_r),
    .rec               (rec),
    .st                (st)
  );

  assign in_if.ready = !out_valid_r || !st.at_last;
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_valid_r && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dual_r      <= 1'b0;
    end else if (in_fire && st.emit) begin
      out_valid_r <= 1'b1;
      dual_r      <= st.dual;
    end else if (out_fire) begin
      if (dual_r) begin
        dual_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // second transfer of an all-groups frame only swaps the group
  always_ff @(posedge clk) begin
    if (in_fire && st.emit) begin
      out_rec_r <= rec;
      group2_r  <= st.group2;
    end else if (out_fire && dual_r) begin
      out_rec_r.light_group <= group2_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_rec_r.kind;
  assign out_if.light_group  = out_rec_r.light_group;
  assign out_if.effect       = out_rec_r.effect;
  assign out_if.color_rgba   = out_rec_r.color_rgba;
  assign out_if.day_of_week  = out_rec_r.day_of_week;
  assign out_if.hour         = out_rec_r.hour;
  assign out_if.minute       = out_rec_r.minute;
  assign out_if.second       = out_rec_r.second;
  assign out_if.day_of_month = out_rec_r.day_of_month;
  assign out_if.month        = out_rec_r.month;
  assign out_if.year         = out_rec_r.year;
  assign out_if.sound_snooze = out_rec_r.sound_snooze;

  `CFU_ASSERT_NOW(a_dual_needs_valid, dual_r, out_valid_r, "second record pending without valid")
  `CFU_ASSERT_NOW(a_emit_on_last, in_fire && st.emit, st.at_last && !out_valid_r, "record emitted off the last byte or over a held record")
  `CFU_ASSERT_NEXT(a_dual_second, out_fire && dual_r, out_valid_r && !dual_r && out_rec_r.kind == cfu_pkg::KIND_LIGHT, "second all-groups record missing")
  `CFU_ASSERT_NOW(a_kind_range, out_valid_r, out_rec_r.kind <= cfu_pkg::KIND_CLOCK, "record kind out of range")

endmodule
